// File: design/drg_pkg.sv
// Shared types and constants for the dynamic resolution governor.
// Used by drg_cfg, drg_core and dynamic_resolution_governor; depends on nothing.
`default_nettype none

package drg_pkg;

  // Resolution ladder.
  localparam int RUNGS       = 8;
  localparam int START_LEVEL = 7;
  localparam int TOP_RUNG_I  = (RUNGS < 1) ? 0 : ((RUNGS > 256) ? 255 : RUNGS - 1);
  localparam int RESET_RUNG_I = (START_LEVEL < TOP_RUNG_I) ? START_LEVEL : TOP_RUNG_I;
  localparam logic [7:0] TOP_RUNG   = 8'(TOP_RUNG_I);
  localparam logic [7:0] RESET_RUNG = 8'(RESET_RUNG_I);

  // Field widths.
  localparam int BUSY_W   = 11;
  localparam int TIME_W   = 20;
  localparam int RATIO_W  = 10;
  localparam int FRAMES_W = 16;
  localparam int COUNT_W  = 32;
  localparam int LEVEL_W  = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register map, index = paddr[4:2].
  typedef enum logic [2:0] {
    REG_CPU_HIGH = 3'd0,
    REG_GPU_HIGH = 3'd1,
    REG_GPU_LOW  = 3'd2,
    REG_TARGET   = 3'd3,
    REG_SLOW     = 3'd4,
    REG_FAST     = 3'd5,
    REG_WARMUP   = 3'd6,
    REG_COOLDOWN = 3'd7
  } reg_idx_t;

  localparam logic [BUSY_W-1:0]   RST_CPU_HIGH = 11'd922;
  localparam logic [BUSY_W-1:0]   RST_GPU_HIGH = 11'd973;
  localparam logic [BUSY_W-1:0]   RST_GPU_LOW  = 11'd768;
  localparam logic [TIME_W-1:0]   RST_TARGET   = 20'd16667;
  localparam logic [RATIO_W-1:0]  RST_SLOW     = 10'd269;
  localparam logic [RATIO_W-1:0]  RST_FAST     = 10'd218;
  localparam logic [FRAMES_W-1:0] RST_WARMUP   = 16'd30;
  localparam logic [FRAMES_W-1:0] RST_COOLDOWN = 16'd15;

  typedef enum logic [1:0] {
    DEC_HOLD = 2'd0,
    DEC_DOWN = 2'd1,
    DEC_UP   = 2'd2
  } decision_t;

  typedef enum logic [1:0] {
    BOT_BALANCED = 2'd0,
    BOT_CPU      = 2'd1,
    BOT_GPU      = 2'd2
  } bottleneck_t;

  typedef enum logic [3:0] {
    RSN_CPU_HOLD    = 4'd0,
    RSN_DOWN_LOCKED = 4'd1,
    RSN_LOWEST      = 4'd2,
    RSN_DOWN        = 4'd3,
    RSN_UP_LOCKED   = 4'd4,
    RSN_NATIVE      = 4'd5,
    RSN_UP          = 4'd6,
    RSN_SLOW_OTHER  = 4'd7,
    RSN_OK          = 4'd8
  } reason_t;

  typedef struct packed {
    logic [BUSY_W-1:0]   cpu_high_mark;
    logic [BUSY_W-1:0]   gpu_high_mark;
    logic [BUSY_W-1:0]   gpu_low_mark;
    logic [TIME_W-1:0]   target_frame_us;
    logic [RATIO_W-1:0]  slow_ratio;
    logic [RATIO_W-1:0]  fast_ratio;
    logic [FRAMES_W-1:0] warmup_frames;
    logic [FRAMES_W-1:0] cooldown_frames;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] frame_time_us;
    logic [BUSY_W-1:0] gpu_busy;
    logic [BUSY_W-1:0] cpu_busy;
  } sample_t;

  typedef struct packed {
    reason_t            reason_code;
    bottleneck_t        bottleneck;
    decision_t          decision;
    logic [LEVEL_W-1:0] current_level;
  } result_t;

endpackage

`default_nettype wire

// File: design/dynamic_resolution_governor.sv
// Top level of the dynamic resolution governor: stream ports, APB-style configuration port.
// Depends on drg_pkg, drg_cfg and drg_core.
`default_nettype none

// One frame sample (CPU busy, GPU busy, frame time) enters per word on the s_ side and
// one result word (rung, decision, bottleneck, reason) leaves per sample on the m_ side,
// in order. The block takes a new sample every cycle unless the result side stalls; a
// sample is accepted into the sample register and its result is then loaded into the
// result register, with the classification, both threshold multiplies and the rung update
// done combinationally between them. Input stalls only when both registers are full and
// m_tready is low. Write configuration only while no sample is in flight.

module dynamic_resolution_governor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB-style configuration port, register i at byte address 4*i.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [drg_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [drg_pkg::DATA_W-1:0]      pwdata,
  output logic      [drg_pkg::DATA_W-1:0]      prdata,
  output logic                                 pready,
  // Sample stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // cpu_busy[10:0], gpu_busy[21:11], frame_time_us[41:22], zero[47:42]
  input  wire logic [drg_pkg::IN_DATA_W-1:0]   s_tdata,
  // Result stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // current_level[7:0], decision[9:8], bottleneck[11:10], reason_code[15:12]
  output logic      [drg_pkg::OUT_DATA_W-1:0]  m_tdata
);

  drg_pkg::cfg_t    cfg;
  drg_pkg::sample_t sample;
  drg_pkg::result_t result;

  assign sample  = drg_pkg::sample_t'(s_tdata[41:0]);
  assign m_tdata = result;

  drg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (sample),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

endmodule

`default_nettype wire

// File: design/drg_cfg.sv
// Configuration register file of the governor behind an APB-style port.
// Depends on drg_pkg for the register map, reset values and cfg_t.
`default_nettype none

module drg_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [drg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [drg_pkg::DATA_W-1:0]  pwdata,
  output logic      [drg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output drg_pkg::cfg_t                    cfg
);

  drg_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = drg_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpu_high_mark   <= drg_pkg::RST_CPU_HIGH;
      cfg.gpu_high_mark   <= drg_pkg::RST_GPU_HIGH;
      cfg.gpu_low_mark    <= drg_pkg::RST_GPU_LOW;
      cfg.target_frame_us <= drg_pkg::RST_TARGET;
      cfg.slow_ratio      <= drg_pkg::RST_SLOW;
      cfg.fast_ratio      <= drg_pkg::RST_FAST;
      cfg.warmup_frames   <= drg_pkg::RST_WARMUP;
      cfg.cooldown_frames <= drg_pkg::RST_COOLDOWN;
    end else if (wr) begin
      case (idx)
        drg_pkg::REG_CPU_HIGH: cfg.cpu_high_mark   <= pwdata[drg_pkg::BUSY_W-1:0];
        drg_pkg::REG_GPU_HIGH: cfg.gpu_high_mark   <= pwdata[drg_pkg::BUSY_W-1:0];
        drg_pkg::REG_GPU_LOW:  cfg.gpu_low_mark    <= pwdata[drg_pkg::BUSY_W-1:0];
        drg_pkg::REG_TARGET:   cfg.target_frame_us <= pwdata[drg_pkg::TIME_W-1:0];
        drg_pkg::REG_SLOW:     cfg.slow_ratio      <= pwdata[drg_pkg::RATIO_W-1:0];
        drg_pkg::REG_FAST:     cfg.fast_ratio      <= pwdata[drg_pkg::RATIO_W-1:0];
        drg_pkg::REG_WARMUP:   cfg.warmup_frames   <= pwdata[drg_pkg::FRAMES_W-1:0];
        drg_pkg::REG_COOLDOWN: cfg.cooldown_frames <= pwdata[drg_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      drg_pkg::REG_CPU_HIGH: prdata = 32'(cfg.cpu_high_mark);
      drg_pkg::REG_GPU_HIGH: prdata = 32'(cfg.gpu_high_mark);
      drg_pkg::REG_GPU_LOW:  prdata = 32'(cfg.gpu_low_mark);
      drg_pkg::REG_TARGET:   prdata = 32'(cfg.target_frame_us);
      drg_pkg::REG_SLOW:     prdata = 32'(cfg.slow_ratio);
      drg_pkg::REG_FAST:     prdata = 32'(cfg.fast_ratio);
      drg_pkg::REG_WARMUP:   prdata = 32'(cfg.warmup_frames);
      drg_pkg::REG_COOLDOWN: prdata = 32'(cfg.cooldown_frames);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/drg_core.sv
// Governor datapath: sample register, decision logic, governor state and result register.
// Depends on drg_pkg for the sample, result and configuration types.
`default_nettype none

module drg_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire drg_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire drg_pkg::sample_t  in_sample,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output drg_pkg::result_t       out_result
);

  // Sample register.
  logic              smp_valid;
  drg_pkg::sample_t  smp;
  logic              out_free;
  logic              adv;

  // Governor state.
  logic [drg_pkg::LEVEL_W-1:0] rung;
  logic [drg_pkg::COUNT_W-1:0] frame_count;
  logic [drg_pkg::COUNT_W-1:0] last_change_frame;
  logic                        changed_once;
  logic                        warmed_up;

  logic [drg_pkg::LEVEL_W-1:0] rung_next;
  logic [drg_pkg::COUNT_W-1:0] frame_count_next;
  logic                        warmed_up_next;
  logic                        change;

  logic [27:0]                 scaled;
  logic [29:0]                 slow_lim;
  logic [29:0]                 fast_lim;
  logic                        slow;
  logic                        fast;
  logic [drg_pkg::COUNT_W-1:0] since_change;
  logic                        may_change;
  drg_pkg::result_t            res;

  assign out_free = !out_valid || out_ready;
  assign adv      = smp_valid && out_free;
  assign in_ready = !smp_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      smp <= in_sample;
    end
  end

  always_comb begin
    frame_count_next = frame_count + 32'd1;
    warmed_up_next   = warmed_up || (frame_count_next > 32'(cfg.warmup_frames));
    since_change     = frame_count_next - last_change_frame;
    may_change       = warmed_up_next &&
                       (!changed_once || (since_change >= 32'(cfg.cooldown_frames)));

    scaled   = {smp.frame_time_us, 8'd0};
    slow_lim = 30'(cfg.target_frame_us) * 30'(cfg.slow_ratio);
    fast_lim = 30'(cfg.target_frame_us) * 30'(cfg.fast_ratio);
    slow     = {2'b00, scaled} > slow_lim;
    fast     = {2'b00, scaled} < fast_lim;

    if (smp.cpu_busy >= cfg.cpu_high_mark) begin
      res.bottleneck = drg_pkg::BOT_CPU;
    end else if (smp.gpu_busy >= cfg.gpu_high_mark) begin
      res.bottleneck = drg_pkg::BOT_GPU;
    end else begin
      res.bottleneck = drg_pkg::BOT_BALANCED;
    end

    rung_next    = rung;
    change       = 1'b0;
    res.decision = drg_pkg::DEC_HOLD;

    if (res.bottleneck == drg_pkg::BOT_CPU) begin
      res.reason_code = drg_pkg::RSN_CPU_HOLD;
    end else if (slow && res.bottleneck == drg_pkg::BOT_GPU) begin
      if (!may_change) begin
        res.reason_code = drg_pkg::RSN_DOWN_LOCKED;
      end else if (rung == 8'd0) begin
        res.reason_code = drg_pkg::RSN_LOWEST;
      end else begin
        rung_next       = rung - 8'd1;
        change          = 1'b1;
        res.decision    = drg_pkg::DEC_DOWN;
        res.reason_code = drg_pkg::RSN_DOWN;
      end
    end else if (fast && smp.gpu_busy <= cfg.gpu_low_mark) begin
      if (!may_change) begin
        res.reason_code = drg_pkg::RSN_UP_LOCKED;
      end else if (rung >= drg_pkg::TOP_RUNG) begin
        res.reason_code = drg_pkg::RSN_NATIVE;
      end else begin
        rung_next       = rung + 8'd1;
        change          = 1'b1;
        res.decision    = drg_pkg::DEC_UP;
        res.reason_code = drg_pkg::RSN_UP;
      end
    end else if (slow) begin
      res.reason_code = drg_pkg::RSN_SLOW_OTHER;
    end else begin
      res.reason_code = drg_pkg::RSN_OK;
    end

    res.current_level = rung_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rung              <= drg_pkg::RESET_RUNG;
      frame_count       <= '0;
      last_change_frame <= '0;
      changed_once      <= 1'b0;
      warmed_up         <= 1'b0;
    end else if (adv) begin
      rung        <= rung_next;
      frame_count <= frame_count_next;
      warmed_up   <= warmed_up_next;
      if (change) begin
        last_change_frame <= frame_count_next;
        changed_once      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= res;
    end
  end

  a_rung_in_range: assert property (@(posedge clk) disable iff (rst)
    rung <= drg_pkg::TOP_RUNG)
    else $error("rung above top of ladder");

  a_down_step: assert property (@(posedge clk) disable iff (rst)
    (adv && res.decision == drg_pkg::DEC_DOWN) |=> (rung == $past(rung) - 8'd1))
    else $error("step down did not lower rung by one");

  a_hold_keeps_rung: assert property (@(posedge clk) disable iff (rst)
    (adv && res.decision == drg_pkg::DEC_HOLD) |=> $stable(rung))
    else $error("rung moved on a hold decision");

  a_count_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(frame_count))
    else $error("frame count moved without a sample");

  a_warm_sticky: assert property (@(posedge clk) disable iff (rst)
    warmed_up |=> warmed_up)
    else $error("warmup flag cleared outside reset");

endmodule

`default_nettype wire

// File: sim/governor_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the dynamic resolution governor testbench: a cycle-free predictor of the
// rung ladder, warmup and cooldown locks, and a store of expected result words.
// Depends on drg_pkg for the register, sample and result types.

package governor_check_pkg;
  import drg_pkg::*;

  class governor_checker;
    cfg_t        cfg;
    logic [7:0]  rung;
    logic [31:0] frame_count;
    logic [31:0] last_change;
    bit          changed_once;
    bit          warmed_up;
    result_t     expected_q[$];
    int          errors;

    function new();
      cfg.cpu_high_mark   = 11'd922;
      cfg.gpu_high_mark   = 11'd973;
      cfg.gpu_low_mark    = 11'd768;
      cfg.target_frame_us = 20'd16667;
      cfg.slow_ratio      = 10'd269;
      cfg.fast_ratio      = 10'd218;
      cfg.warmup_frames   = 16'd30;
      cfg.cooldown_frames = 16'd15;
      rung = (START_LEVEL < top_rung()) ? 8'(START_LEVEL) : top_rung();
      frame_count  = '0;
      last_change  = '0;
      changed_once = 1'b0;
      warmed_up    = 1'b0;
      errors       = 0;
    endfunction

    function logic [7:0] top_rung();
      int n;
      n = RUNGS;
      if (n < 1) n = 1;
      if (n > 256) n = 256;
      return 8'(n - 1);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void write_reg(input reg_idx_t idx, input logic [31:0] value);
      case (idx)
        REG_CPU_HIGH: cfg.cpu_high_mark   = value[10:0];
        REG_GPU_HIGH: cfg.gpu_high_mark   = value[10:0];
        REG_GPU_LOW:  cfg.gpu_low_mark    = value[10:0];
        REG_TARGET:   cfg.target_frame_us = value[19:0];
        REG_SLOW:     cfg.slow_ratio      = value[9:0];
        REG_FAST:     cfg.fast_ratio      = value[9:0];
        REG_WARMUP:   cfg.warmup_frames   = value[15:0];
        REG_COOLDOWN: cfg.cooldown_frames = value[15:0];
        default: ;
      endcase
    endfunction

    // Advances the ladder by one accepted frame and records the word it must produce.
    function void note_frame(input sample_t s);
      logic [29:0] scaled;
      logic [29:0] slow_lim;
      logic [29:0] fast_lim;
      logic [31:0] since_change;
      bit          slow;
      bit          fast;
      bit          free;
      bottleneck_t bot;
      decision_t   dec;
      reason_t     why;
      result_t     r;

      frame_count = frame_count + 32'd1;
      if (frame_count > {16'd0, cfg.warmup_frames}) warmed_up = 1'b1;
      since_change = frame_count - last_change;
      free = warmed_up && (!changed_once || since_change >= {16'd0, cfg.cooldown_frames});

      if (s.cpu_busy >= cfg.cpu_high_mark) bot = BOT_CPU;
      else if (s.gpu_busy >= cfg.gpu_high_mark) bot = BOT_GPU;
      else bot = BOT_BALANCED;

      scaled   = {2'b00, s.frame_time_us, 8'd0};
      slow_lim = cfg.target_frame_us * cfg.slow_ratio;
      fast_lim = cfg.target_frame_us * cfg.fast_ratio;
      slow = scaled > slow_lim;
      fast = scaled < fast_lim;

      dec = DEC_HOLD;
      if (bot == BOT_CPU) begin
        why = RSN_CPU_HOLD;
      end else if (slow && bot == BOT_GPU) begin
        if (!free) why = RSN_DOWN_LOCKED;
        else if (rung == 8'd0) why = RSN_LOWEST;
        else begin
          rung = rung - 8'd1;
          last_change  = frame_count;
          changed_once = 1'b1;
          dec = DEC_DOWN;
          why = RSN_DOWN;
        end
      end else if (fast && s.gpu_busy <= cfg.gpu_low_mark) begin
        if (!free) why = RSN_UP_LOCKED;
        else if (rung >= top_rung()) why = RSN_NATIVE;
        else begin
          rung = rung + 8'd1;
          last_change  = frame_count;
          changed_once = 1'b1;
          dec = DEC_UP;
          why = RSN_UP;
        end
      end else if (slow) begin
        why = RSN_SLOW_OTHER;
      end else begin
        why = RSN_OK;
      end

      r.current_level = rung;
      r.decision      = dec;
      r.bottleneck    = bot;
      r.reason_code   = why;
      expected_q.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no frame outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.current_level !== want.current_level) begin
        $error("current_level: expected %0d, got %0d", want.current_level, got.current_level);
        errors++;
      end
      if (got.decision !== want.decision) begin
        $error("decision: expected %0d, got %0d", want.decision, got.decision);
        errors++;
      end
      if (got.bottleneck !== want.bottleneck) begin
        $error("bottleneck: expected %0d, got %0d", want.bottleneck, got.bottleneck);
        errors++;
      end
      if (got.reason_code !== want.reason_code) begin
        $error("reason_code: expected %0d, got %0d", want.reason_code, got.reason_code);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: sim/tb_dynamic_resolution_governor.sv
`timescale 1ns / 100ps
// Top-level testbench for dynamic_resolution_governor: directed and random frame samples
// under several register settings, with random stalls on both streams.
// Depends on drg_pkg, governor_check_pkg and the governor RTL.

module tb_dynamic_resolution_governor;
  import drg_pkg::*;
  import governor_check_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    TREND_MIXED,
    TREND_PUSH_DOWN,
    TREND_PULL_UP
  } trend_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_W-1:0]     paddr    = '0;
  logic [DATA_W-1:0]     pwdata   = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  governor_checker gov_chk = new();
  sample_t         frame_q[$];
  int              frames_queued = 0;
  int              frames_in     = 0;
  int              idle_cycles   = 0;
  int              gap_left      = 0;
  int              burst_left    = 0;
  int              holdoffs      = 0;
  bit              s_took        = 1'b0;

  dynamic_resolution_governor dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Both streams are sampled here; the idle counter is the run's watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      s_took = s_tvalid && s_tready;
      if (s_took) begin
        gov_chk.note_frame(sample_t'(s_tdata[$bits(sample_t)-1:0]));
        frames_in++;
      end
      if (m_tvalid && m_tready) gov_chk.check_result(result_t'(m_tdata));
      if (s_took || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (frame_q.size() != 0) begin
        s_tdata  <= IN_DATA_W'(frame_q.pop_front());
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else burst_left--;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of full rate, random stalls and fixed stall patterns, plus two long
  // hold-offs while the sender keeps offering words so that the block backs up.
  initial begin : receiver
    int stretch;
    int mode;
    int tick;
    forever begin
      stretch = $urandom_range(10, 120);
      mode    = $urandom_range(0, 3);
      for (tick = 0; tick < stretch; tick++) begin
        @(negedge clk);
        if (holdoffs < 2 && frames_in >= 400 + 700 * holdoffs) begin
          m_tready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          holdoffs++;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (tick % 4) < 2;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gov_chk.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fills the bits above a register's width with junk now and then; they must be dropped.
  function automatic logic [31:0] with_junk(input logic [31:0] field, input int width);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    return field | ((junk >> width) << width);
  endfunction

  task automatic program_cfg(input cfg_t c);
    apb_write(REG_CPU_HIGH, with_junk(32'(c.cpu_high_mark), 11));
    apb_write(REG_GPU_HIGH, with_junk(32'(c.gpu_high_mark), 11));
    apb_write(REG_GPU_LOW,  with_junk(32'(c.gpu_low_mark), 11));
    apb_write(REG_TARGET,   with_junk(32'(c.target_frame_us), 20));
    apb_write(REG_SLOW,     with_junk(32'(c.slow_ratio), 10));
    apb_write(REG_FAST,     with_junk(32'(c.fast_ratio), 10));
    apb_write(REG_WARMUP,   with_junk(32'(c.warmup_frames), 16));
    apb_write(REG_COOLDOWN, with_junk(32'(c.cooldown_frames), 16));
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.cpu_high_mark = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                  : 11'($urandom_range(700, 1024));
    c.gpu_high_mark = 11'($urandom_range(600, 1024));
    c.gpu_low_mark  = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                  : 11'($urandom_range(0, c.gpu_high_mark));
    c.target_frame_us = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                    : 20'($urandom_range(1000, 60000));
    c.slow_ratio = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(256, 400));
    c.fast_ratio = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(100, 256));
    c.warmup_frames   = 16'($urandom);
    c.cooldown_frames = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 300))
                                                    : 16'($urandom_range(0, 12));
    return c;
  endfunction

  function automatic logic [31:0] near_mark(input logic [31:0] mark);
    case ($urandom_range(0, 5))
      0: return mark - 32'd1;
      1: return mark;
      2: return mark + 32'd1;
      3: return $urandom;
      default: return $urandom_range(0, mark);
    endcase
  endfunction

  function automatic logic [31:0] below_mark(input logic [31:0] mark);
    return (mark == 0) ? 32'd0 : $urandom_range(0, mark - 1);
  endfunction

  // Frame time at which target * ratio / 256 is crossed, clipped to the field.
  function automatic logic [31:0] time_mark(input logic [19:0] target, input logic [9:0] ratio);
    logic [31:0] t;
    t = (32'(target) * 32'(ratio)) >> 8;
    return (t > 32'hFFFFF) ? 32'hFFFFF : t;
  endfunction

  function automatic sample_t random_frame(input trend_t trend);
    sample_t     f;
    cfg_t        c;
    logic [31:0] slow_at;
    logic [31:0] fast_at;
    c       = gov_chk.cfg;
    slow_at = time_mark(c.target_frame_us, c.slow_ratio);
    fast_at = time_mark(c.target_frame_us, c.fast_ratio);
    if ($urandom_range(0, 9) == 0) begin
      f.cpu_busy      = 11'($urandom);
      f.gpu_busy      = 11'($urandom);
      f.frame_time_us = 20'($urandom);
      return f;
    end
    f.cpu_busy = ($urandom_range(0, 3) == 0) ? 11'(near_mark(32'(c.cpu_high_mark)))
                                             : 11'(below_mark(32'(c.cpu_high_mark)));
    case (trend)
      TREND_PUSH_DOWN: begin
        f.gpu_busy      = 11'(c.gpu_high_mark + $urandom_range(0, 40));
        f.frame_time_us = 20'(slow_at + 1 + $urandom_range(0, 2000));
      end
      TREND_PULL_UP: begin
        f.gpu_busy      = 11'($urandom_range(0, c.gpu_low_mark));
        f.frame_time_us = 20'(below_mark(fast_at));
      end
      default: begin
        f.gpu_busy = ($urandom_range(0, 1) == 0) ? 11'(near_mark(32'(c.gpu_high_mark)))
                                                 : 11'(near_mark(32'(c.gpu_low_mark)));
        case ($urandom_range(0, 3))
          0: f.frame_time_us = 20'(near_mark(slow_at));
          1: f.frame_time_us = 20'(near_mark(fast_at));
          2: f.frame_time_us = 20'($urandom_range(fast_at, slow_at));
          default: f.frame_time_us = 20'($urandom);
        endcase
      end
    endcase
    return f;
  endfunction

  function automatic sample_t frame_of(input logic [10:0] cpu, input logic [10:0] gpu,
                                       input logic [19:0] ft);
    sample_t f;
    f.cpu_busy      = cpu;
    f.gpu_busy      = gpu;
    f.frame_time_us = ft;
    return f;
  endfunction

  task automatic queue_frame(input sample_t f);
    frame_q.push_back(f);
    frames_queued++;
  endtask

  // Runs with warmup 2 and no cooldown: the locks first, then the ladder walked to both
  // ends and every exact threshold.
  task automatic queue_directed_frames();
    queue_frame(frame_of(11'd0, 11'd1024, 20'd20000));     // saturated and slow, still warming
    queue_frame(frame_of(11'd0, 11'd0, 20'd0));            // fast and idle, still warming
    queue_frame(frame_of(11'd1024, 11'd1024, 20'hFFFFF));  // CPU-bound wins over the GPU
    queue_frame(frame_of(11'd0, 11'd0, 20'd10000));        // already at the top rung
    repeat (7) queue_frame(frame_of(11'd0, 11'd1024, 20'hFFFFF));
    queue_frame(frame_of(11'd0, 11'd1024, 20'hFFFFF));     // no rung below zero
    queue_frame(frame_of(11'd0, 11'd500, 20'd20000));
    queue_frame(frame_of(11'd0, 11'd500, 20'd16000));
    repeat (7) queue_frame(frame_of(11'd921, 11'd768, 20'd14192));
    queue_frame(frame_of(11'd921, 11'd768, 20'd14192));
    queue_frame(frame_of(11'd921, 11'd973, 20'd17515));
    queue_frame(frame_of(11'h7FF, 11'h7FF, 20'hFFFFF));
    queue_frame(frame_of(11'd922, 11'd0, 20'd0));
  endtask

  task automatic queue_random_frames(input int count);
    int     streak;
    trend_t trend;
    streak = 0;
    trend  = TREND_MIXED;
    repeat (count) begin
      if (streak == 0) begin
        streak = $urandom_range(5, 30);
        trend  = trend_t'($urandom_range(TREND_MIXED, TREND_PULL_UP));
      end
      streak--;
      queue_frame(random_frame(trend));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (frames_in != frames_queued || gov_chk.outstanding() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : main_flow
    cfg_t c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_write(REG_WARMUP, 32'd2);
    apb_write(REG_COOLDOWN, 32'd0);
    @(posedge clk);
    queue_directed_frames();
    wait_drained();

    // Low corner: every sample below the all-ones CPU mark reads as GPU-bound, and any nonzero time is slow.
    c = '0;
    c.cpu_high_mark = '1;
    program_cfg(c);
    @(posedge clk);
    queue_random_frames(100);
    wait_drained();

    // High corner: almost every frame is fast, and the cooldown never expires.
    c = '1;
    program_cfg(c);
    @(posedge clk);
    queue_random_frames(100);
    wait_drained();

    repeat (7) begin
      program_cfg(random_cfg());
      @(posedge clk);
      queue_random_frames(250);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (gov_chk.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
